// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is asserted (active-low reset).
`define CDLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cdlc assertion failed");

// Concurrent assertion that is also checked across reset.
`define CDLC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cdlc assertion failed");

`endif

// File: hdl/cdlc_pkg.sv
// Shared constants, codes and types of the chunked download link controller.
// No dependencies; compiled first.
package cdlc_pkg;

    localparam int TIME_BITS       = 32;
    localparam int LEN_BITS        = 11;
    localparam int CHUNK_BITS      = 16;
    localparam int CODE_BITS       = 8;
    localparam int ACT_BITS        = 4;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int MAX_RESULTS     = 3;
    localparam int RES_CNT_BITS    = 2;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_BITS   = 2;
    localparam int FIFO_CNT_BITS   = 3;

    localparam logic [LEN_BITS-1:0]  MAX_FRAME_BYTES  = 11'd1024;
    localparam logic [LEN_BITS-1:0]  MIN_FRAME_BYTES  = 11'd5;
    localparam logic [LEN_BITS-1:0]  STATUS_HDR_BYTES = 11'd6;
    localparam logic [LEN_BITS-1:0]  CHUNK_HDR_BYTES  = 11'd8;
    localparam logic [TIME_BITS-1:0] LED_HOLD_MS      = 32'd50;

    // input modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_FRAME    = 2'd1;
    localparam logic [1:0] MODE_PING_REQ = 2'd2;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_BITS-1:0] ACT_PING     = 4'd1;
    localparam logic [ACT_BITS-1:0] ACT_REQUEST  = 4'd2;
    localparam logic [ACT_BITS-1:0] ACT_FORWARD  = 4'd3;
    localparam logic [ACT_BITS-1:0] ACT_CAPTURE  = 4'd4;
    localparam logic [ACT_BITS-1:0] ACT_STATUS   = 4'd5;
    localparam logic [ACT_BITS-1:0] ACT_COMPLETE = 4'd6;
    localparam logic [ACT_BITS-1:0] ACT_PONG     = 4'd7;
    localparam logic [ACT_BITS-1:0] ACT_LOST     = 4'd8;
    localparam logic [ACT_BITS-1:0] ACT_CRC_DROP = 4'd9;
    localparam logic [ACT_BITS-1:0] ACT_SHORT    = 4'd10;
    localparam logic [ACT_BITS-1:0] ACT_UNKNOWN  = 4'd11;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PING_CODE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPTURE_CODE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STATUS_CODE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNK_CODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINK_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY_IVL    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEPALIVE    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_CHUNK   = 3'd7;

    // configuration reset values
    localparam logic [CODE_BITS-1:0] RST_PING_CODE    = 8'd1;
    localparam logic [CODE_BITS-1:0] RST_CAPTURE_CODE = 8'h12;
    localparam logic [CODE_BITS-1:0] RST_STATUS_CODE  = 8'h11;
    localparam logic [CODE_BITS-1:0] RST_CHUNK_CODE   = 8'h13;
    localparam logic [15:0]          RST_LINK_TIMEOUT = 16'd5000;
    localparam logic [15:0]          RST_RETRY_IVL    = 16'd500;
    localparam logic [15:0]          RST_KEEPALIVE    = 16'd2000;
    localparam logic [LEN_BITS-1:0]  RST_FULL_CHUNK   = 11'd200;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [1:0]            mode;
        logic [LEN_BITS-1:0]   frame_len;
        logic [CODE_BITS-1:0]  kiss_byte;
        logic [CODE_BITS-1:0]  command;
        logic                  crc_good;
        logic [CHUNK_BITS-1:0] chunk_tag;
    } t_in_item;

    typedef struct packed {
        logic [ACT_BITS-1:0]   action;
        logic [CHUNK_BITS-1:0] chunk_number;
        logic [LEN_BITS-1:0]   payload_len;
        logic                  link_online;
        logic                  activity_led;
        logic                  downloading;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [CODE_BITS-1:0] ping_code;
        logic [CODE_BITS-1:0] capture_code;
        logic [CODE_BITS-1:0] status_code;
        logic [CODE_BITS-1:0] chunk_code;
        logic [15:0]          link_timeout_ms;
        logic [15:0]          retry_interval_ms;
        logic [15:0]          keepalive_interval_ms;
        logic [LEN_BITS-1:0]  full_chunk_bytes;
    } t_cfg;

    // results of one item, handed from the step logic to the result queue
    typedef struct packed {
        logic [RES_CNT_BITS-1:0]             cnt;
        t_out_item [MAX_RESULTS-1:0]         res;
    } t_push;

endpackage

// File: hdl/cdlc_in_if.sv
// Input item channel: valid/ready handshake with a t_in_item payload.
// Depends on cdlc_pkg.
interface cdlc_in_if;
    import cdlc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/cdlc_out_if.sv
// Result item channel: valid/ready handshake with a t_out_item payload.
// Depends on cdlc_pkg.
interface cdlc_out_if;
    import cdlc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/cdlc_fifo.sv
// Result queue: takes up to three result items per cycle, hands out one.
// Depends on cdlc_pkg.
module cdlc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdlc_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output cdlc_pkg::t_out_item o_item,
    output logic                o_room
);
    import cdlc_pkg::*;

    t_out_item                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, n_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp, n_rp;
    logic [FIFO_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                     pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    // room for a full burst of results
    assign o_room  = (r_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS));
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp + FIFO_PTR_BITS'(i_push.cnt);
        n_rp  = r_rp + FIFO_PTR_BITS'(pop);
        n_cnt = r_cnt + FIFO_CNT_BITS'(i_push.cnt) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_CNT_BITS'(k) < i_push.cnt) begin
                r_mem[r_wp + FIFO_PTR_BITS'(k)] <= i_push.res[k];
            end
        end
    end
endmodule

// File: hdl/cdlc_step.sv
// Input register, configuration and link state, and the per-item step logic.
// Depends on cdlc_pkg.
module cdlc_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  cdlc_pkg::t_in_item                 i_in_item,
    output logic                               o_in_ready,
    input  logic                               i_room,
    input  logic                               i_cfg_we,
    input  logic [cdlc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [cdlc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output cdlc_pkg::t_push                    o_push
);
    import cdlc_pkg::*;

    logic                  r_in_vld;
    t_in_item              r_in;
    t_cfg                  r_cfg;

    t_time                 r_clock, n_clock;
    t_time                 r_heard, n_heard;
    t_time                 r_req, n_req;
    t_time                 r_ping, n_ping;
    t_time                 r_led_since, n_led_since;
    logic                  r_online, n_online;
    logic                  r_dl, n_dl;
    logic                  r_pong, n_pong;
    logic                  r_led, n_led;
    logic [CHUNK_BITS-1:0] r_next, n_next;

    logic                  fire;
    logic [LEN_BITS-1:0]   flen;
    logic [LEN_BITS-1:0]   dlen;
    logic [RES_CNT_BITS-1:0] cnt;
    t_out_item [MAX_RESULTS-1:0] res;

    assign fire       = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ping_code             <= RST_PING_CODE;
            r_cfg.capture_code          <= RST_CAPTURE_CODE;
            r_cfg.status_code           <= RST_STATUS_CODE;
            r_cfg.chunk_code            <= RST_CHUNK_CODE;
            r_cfg.link_timeout_ms       <= RST_LINK_TIMEOUT;
            r_cfg.retry_interval_ms     <= RST_RETRY_IVL;
            r_cfg.keepalive_interval_ms <= RST_KEEPALIVE;
            r_cfg.full_chunk_bytes      <= RST_FULL_CHUNK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PING_CODE:    r_cfg.ping_code             <= i_cfg_data[CODE_BITS-1:0];
                CFG_CAPTURE_CODE: r_cfg.capture_code          <= i_cfg_data[CODE_BITS-1:0];
                CFG_STATUS_CODE:  r_cfg.status_code           <= i_cfg_data[CODE_BITS-1:0];
                CFG_CHUNK_CODE:   r_cfg.chunk_code            <= i_cfg_data[CODE_BITS-1:0];
                CFG_LINK_TIMEOUT: r_cfg.link_timeout_ms       <= i_cfg_data;
                CFG_RETRY_IVL:    r_cfg.retry_interval_ms     <= i_cfg_data;
                CFG_KEEPALIVE:    r_cfg.keepalive_interval_ms <= i_cfg_data;
                CFG_FULL_CHUNK:   r_cfg.full_chunk_bytes      <= i_cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_clock     = r_clock;
        n_heard     = r_heard;
        n_req       = r_req;
        n_ping      = r_ping;
        n_led_since = r_led_since;
        n_online    = r_online;
        n_dl        = r_dl;
        n_pong      = r_pong;
        n_led       = r_led;
        n_next      = r_next;
        cnt         = '0;
        res         = '0;

        flen = (r_in.frame_len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : r_in.frame_len;
        dlen = (flen >= CHUNK_HDR_BYTES) ? flen - CHUNK_HDR_BYTES : '0;

        case (r_in.mode)
            MODE_TICK: begin
                n_clock = r_clock + 1'b1;
                if (r_led && (n_clock - r_led_since) > LED_HOLD_MS) begin
                    n_led = 1'b0;
                end
                if (r_online && (n_clock - r_heard) > t_time'(r_cfg.link_timeout_ms)) begin
                    n_online = 1'b0;
                    res[cnt].action = ACT_LOST;
                    cnt = cnt + 1'b1;
                end
                if ((n_clock - r_ping) > t_time'(r_cfg.keepalive_interval_ms)) begin
                    n_ping = n_clock;
                    res[cnt].action = ACT_PING;
                    cnt = cnt + 1'b1;
                end
                if (r_dl && n_online
                        && (n_clock - r_req) > t_time'(r_cfg.retry_interval_ms)) begin
                    n_req = n_clock;
                    res[cnt].action       = ACT_REQUEST;
                    res[cnt].chunk_number = r_next;
                    cnt = cnt + 1'b1;
                end
            end
            MODE_FRAME: begin
                n_online = 1'b1;
                n_heard  = r_clock;
                if (flen < MIN_FRAME_BYTES) begin
                    res[0].action = ACT_SHORT;
                    cnt = 2'd1;
                end else if (!r_in.crc_good && r_in.command != r_cfg.chunk_code) begin
                    res[0].action = ACT_CRC_DROP;
                    cnt = 2'd1;
                end else if (r_in.kiss_byte != '0) begin
                    cnt = '0;
                end else if (r_in.command == r_cfg.ping_code) begin
                    n_led       = 1'b1;
                    n_led_since = r_clock;
                    if (r_pong) begin
                        n_pong = 1'b0;
                        res[0].action = ACT_PONG;
                        cnt = 2'd1;
                    end
                end else if (r_in.command == r_cfg.capture_code) begin
                    n_dl   = 1'b1;
                    n_next = '0;
                    n_req  = r_clock;
                    res[0].action = ACT_CAPTURE;
                    res[1].action = ACT_REQUEST;
                    cnt = 2'd2;
                end else if (r_in.command == r_cfg.status_code) begin
                    n_led       = 1'b1;
                    n_led_since = r_clock;
                    res[0].action      = ACT_STATUS;
                    res[0].payload_len = (flen >= STATUS_HDR_BYTES) ?
                                         flen - STATUS_HDR_BYTES : '0;
                    cnt = 2'd1;
                end else if (r_in.command == r_cfg.chunk_code) begin
                    if (r_in.chunk_tag == r_next) begin
                        n_led       = 1'b1;
                        n_led_since = r_clock;
                        n_next      = r_next + 1'b1;
                        res[0].action       = ACT_FORWARD;
                        res[0].chunk_number = r_in.chunk_tag;
                        res[0].payload_len  = dlen;
                        if (dlen < r_cfg.full_chunk_bytes) begin
                            n_dl = 1'b0;
                            res[1].action       = ACT_COMPLETE;
                            res[1].chunk_number = r_in.chunk_tag;
                        end else begin
                            n_req = r_clock;
                            res[1].action       = ACT_REQUEST;
                            res[1].chunk_number = n_next;
                        end
                        cnt = 2'd2;
                    end
                end else begin
                    res[0].action = ACT_UNKNOWN;
                    cnt = 2'd1;
                end
            end
            MODE_PING_REQ: begin
                n_pong = 1'b1;
                res[0].action = ACT_PING;
                cnt = 2'd1;
            end
            default: ;
        endcase

        // status bits show the state after the whole step
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k].link_online  = n_online;
            res[k].activity_led = n_led;
            res[k].downloading  = n_dl;
            res[k].last         = (RES_CNT_BITS'(k) == cnt - 1'b1);
        end

        o_push.cnt = fire ? cnt : '0;
        o_push.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_heard     <= '0;
            r_req       <= '0;
            r_ping      <= '0;
            r_led_since <= '0;
            r_online    <= 1'b0;
            r_dl        <= 1'b0;
            r_pong      <= 1'b0;
            r_led       <= 1'b0;
            r_next      <= '0;
        end else if (fire) begin
            r_clock     <= n_clock;
            r_heard     <= n_heard;
            r_req       <= n_req;
            r_ping      <= n_ping;
            r_led_since <= n_led_since;
            r_online    <= n_online;
            r_dl        <= n_dl;
            r_pong      <= n_pong;
            r_led       <= n_led;
            r_next      <= n_next;
        end
    end
endmodule

// File: hdl/chunked_download_link_controller.sv
// Top level of the chunked download link controller: step logic plus result queue.
// Depends on cdlc_pkg, cdlc_in_if, cdlc_out_if, cdlc_step, cdlc_fifo.
//
//   channel    direction  payload      handshake
//   i_item     in         t_in_item    valid/ready
//   o_result   out        t_out_item   valid/ready
//   i_cfg_*    in         16-bit data  write enable only
//
// An item is taken into the input register, stepped once the queue has room, and
// its 0..3 results written to a 4-entry queue. A new item enters every cycle while
// the queue holds at most one result, so items with three results are taken at the
// output's pace. Synchronous active-low reset; configuration returns to defaults
// and the queue empties. A stalled output fills the queue and then holds
// i_item.ready low.
module chunked_download_link_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cdlc_in_if.sink                            i_item,
    cdlc_out_if.source                         o_result,
    input  logic                               i_cfg_we,
    input  logic [cdlc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [cdlc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import cdlc_pkg::*;

    t_push push;
    logic  room;

    cdlc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_item  (i_item.payload),
        .o_in_ready (i_item.ready),
        .i_room     (room),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push)
    );

    cdlc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_result.ready),
        .o_valid (o_result.valid),
        .o_item  (o_result.payload),
        .o_room  (room)
    );
endmodule

// File: hdl/cdlc_checker.sv
// Port-level checks of the chunked download link controller, bound to the top.
// Depends on cdlc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdlc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cdlc_pkg::t_out_item i_out_item
);
    import cdlc_pkg::*;

    `CDLC_ASSERT(a_hold_on_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
    `CDLC_ASSERT(a_action_code, i_clk, i_rst_n, i_out_valid |-> (i_out_item.action != ACT_NONE && i_out_item.action <= ACT_UNKNOWN))
    `CDLC_ASSERT(a_chunk_zero, i_clk, i_rst_n, i_out_valid && i_out_item.action != ACT_REQUEST && i_out_item.action != ACT_FORWARD && i_out_item.action != ACT_COMPLETE |-> i_out_item.chunk_number == '0)
    `CDLC_ASSERT(a_len_zero, i_clk, i_rst_n, i_out_valid && i_out_item.action != ACT_FORWARD && i_out_item.action != ACT_STATUS |-> i_out_item.payload_len == '0)
    `CDLC_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind chunked_download_link_controller cdlc_checker u_cdlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_item  (o_result.payload)
);

// File: tb/sv/tb.sv
// Testbench for chunked_download_link_controller: directed and random item streams,
// checked result by result against a behavioral model of the link controller.
// Depends on cdlc_pkg, cdlc_in_if, cdlc_out_if and the block's RTL.
module tb;
    import cdlc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 120;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [1:0] MODE_IGNORED = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    cdlc_in_if  item_ch ();
    cdlc_out_if result_ch ();

    chunked_download_link_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // link controller model
    t_cfg                  cfg_m;
    t_time                 now_ms, heard_ms, requested_ms, pinged_ms, led_on_ms;
    logic                  link_up, dl_active, pong_pending, led_on;
    logic [CHUNK_BITS-1:0] chunk_due;

    t_out_item expected_actions[$];
    t_out_item step_actions[$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  cycle_count  = 0;
    int  hold_reqs    = 0;
    int  hold_done    = 0;
    int  stall_left   = 0;
    bit  no_idle      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_actions.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_model();
        cfg_m.ping_code             = RST_PING_CODE;
        cfg_m.capture_code          = RST_CAPTURE_CODE;
        cfg_m.status_code           = RST_STATUS_CODE;
        cfg_m.chunk_code            = RST_CHUNK_CODE;
        cfg_m.link_timeout_ms       = RST_LINK_TIMEOUT;
        cfg_m.retry_interval_ms     = RST_RETRY_IVL;
        cfg_m.keepalive_interval_ms = RST_KEEPALIVE;
        cfg_m.full_chunk_bytes      = RST_FULL_CHUNK;
        now_ms       = '0;
        heard_ms     = '0;
        requested_ms = '0;
        pinged_ms    = '0;
        led_on_ms    = '0;
        link_up      = 1'b0;
        dl_active    = 1'b0;
        pong_pending = 1'b0;
        led_on       = 1'b0;
        chunk_due    = '0;
    endfunction

    function automatic void add_action(logic [ACT_BITS-1:0] act, logic [CHUNK_BITS-1:0] chunk,
                                       logic [LEN_BITS-1:0] len);
        t_out_item r;
        r = '0;
        r.action       = act;
        r.chunk_number = chunk;
        r.payload_len  = len;
        step_actions.push_back(r);
    endfunction

    function automatic void light_led();
        led_on    = 1'b1;
        led_on_ms = now_ms;
    endfunction

    function automatic void model_tick();
        now_ms = now_ms + 1;
        if (led_on && (now_ms - led_on_ms) > LED_HOLD_MS)
            led_on = 1'b0;
        if (link_up && (now_ms - heard_ms) > t_time'(cfg_m.link_timeout_ms)) begin
            link_up = 1'b0;
            add_action(ACT_LOST, '0, '0);
        end
        if ((now_ms - pinged_ms) > t_time'(cfg_m.keepalive_interval_ms)) begin
            pinged_ms = now_ms;
            add_action(ACT_PING, '0, '0);
        end
        if (dl_active && link_up && (now_ms - requested_ms) > t_time'(cfg_m.retry_interval_ms)) begin
            requested_ms = now_ms;
            add_action(ACT_REQUEST, chunk_due, '0);
        end
    endfunction

    function automatic void model_frame(t_in_item it);
        logic [LEN_BITS-1:0] flen;
        logic [LEN_BITS-1:0] dlen;
        flen     = (it.frame_len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : it.frame_len;
        link_up  = 1'b1;
        heard_ms = now_ms;
        if (flen < MIN_FRAME_BYTES) begin
            add_action(ACT_SHORT, '0, '0);
        end else if (!it.crc_good && it.command != cfg_m.chunk_code) begin
            add_action(ACT_CRC_DROP, '0, '0);
        end else if (it.kiss_byte == 8'h00) begin
            if (it.command == cfg_m.ping_code) begin
                light_led();
                if (pong_pending) begin
                    pong_pending = 1'b0;
                    add_action(ACT_PONG, '0, '0);
                end
            end else if (it.command == cfg_m.capture_code) begin
                add_action(ACT_CAPTURE, '0, '0);
                dl_active = 1'b1;
                chunk_due = '0;
                add_action(ACT_REQUEST, '0, '0);
                requested_ms = now_ms;
            end else if (it.command == cfg_m.status_code) begin
                light_led();
                add_action(ACT_STATUS, '0,
                           (flen >= STATUS_HDR_BYTES) ? flen - STATUS_HDR_BYTES : '0);
            end else if (it.command == cfg_m.chunk_code) begin
                dlen = (flen >= CHUNK_HDR_BYTES) ? flen - CHUNK_HDR_BYTES : '0;
                if (it.chunk_tag == chunk_due) begin
                    light_led();
                    add_action(ACT_FORWARD, it.chunk_tag, dlen);
                    chunk_due = chunk_due + 1'b1;
                    if (dlen < cfg_m.full_chunk_bytes) begin
                        dl_active = 1'b0;
                        add_action(ACT_COMPLETE, it.chunk_tag, '0);
                    end else begin
                        add_action(ACT_REQUEST, chunk_due, '0);
                        requested_ms = now_ms;
                    end
                end
            end else begin
                add_action(ACT_UNKNOWN, '0, '0);
            end
        end
    endfunction

    function automatic void compute_actions(t_in_item it);
        t_out_item r;
        step_actions.delete();
        case (it.mode)
            MODE_TICK: begin
                model_tick();
            end
            MODE_FRAME: begin
                model_frame(it);
            end
            MODE_PING_REQ: begin
                pong_pending = 1'b1;
                add_action(ACT_PING, '0, '0);
            end
            default: begin
            end
        endcase
        foreach (step_actions[k]) begin
            r              = step_actions[k];
            r.link_online  = link_up;
            r.activity_led = led_on;
            r.downloading  = dl_active;
            r.last         = (k == step_actions.size() - 1);
            expected_actions.push_back(r);
        end
    endfunction

    function automatic string show(t_out_item r);
        return $sformatf("act=%0d chunk=%0d len=%0d online=%b led=%b dl=%b last=%b",
                         r.action, r.chunk_number, r.payload_len, r.link_online,
                         r.activity_led, r.downloading, r.last);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_actions.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("result %0d not expected: got %s", results_seen, show(got));
            return;
        end
        want = expected_actions.pop_front();
        if (got.action !== want.action || got.chunk_number !== want.chunk_number
                || got.payload_len !== want.payload_len || got.link_online !== want.link_online
                || got.activity_led !== want.activity_led
                || got.downloading !== want.downloading || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("result %0d mismatch: expected %s, got %s", results_seen,
                         show(want), show(got));
        end
    endfunction

    // result side: checks each accepted item, then decides ready for the next cycle
    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready)
            check_result(result_ch.payload);
        if (hold_done != hold_reqs) begin
            hold_done  = hold_reqs;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    function automatic t_in_item make_item(logic [1:0] mode, logic [LEN_BITS-1:0] len,
                                           logic [CODE_BITS-1:0] kiss,
                                           logic [CODE_BITS-1:0] cmd, logic crc,
                                           logic [CHUNK_BITS-1:0] tag);
        t_in_item it;
        it.mode      = mode;
        it.frame_len = len;
        it.kiss_byte = kiss;
        it.command   = cmd;
        it.crc_good  = crc;
        it.chunk_tag = tag;
        return it;
    endfunction

    function automatic t_in_item make_random_item(int tick_pct);
        t_in_item it;
        int       sel;
        int       lo;
        it = make_item(MODE_FRAME, LEN_BITS'($urandom_range(0, 2047)),
                       CODE_BITS'($urandom), CODE_BITS'($urandom), 1'($urandom),
                       CHUNK_BITS'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < tick_pct) begin
            it.mode = MODE_TICK;
        end else if (sel < tick_pct + 6) begin
            it.mode = MODE_PING_REQ;
        end else if (sel < tick_pct + 8) begin
            it.mode = MODE_IGNORED;
        end else if (sel < 88) begin
            it.kiss_byte = '0;
            it.crc_good  = 1'b1;
            it.frame_len = LEN_BITS'($urandom_range(MIN_FRAME_BYTES, MAX_FRAME_BYTES));
            sel = $urandom_range(0, 9);
            if (!dl_active && $urandom_range(0, 9) < 4) begin
                it.command = cfg_m.capture_code;
            end else if (sel < 2) begin
                it.command = cfg_m.ping_code;
            end else if (sel < 3) begin
                it.command = cfg_m.status_code;
            end else if (sel < 4) begin
                it.command = cfg_m.capture_code;
            end else begin
                it.command  = cfg_m.chunk_code;
                it.crc_good = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) != 0)
                    it.chunk_tag = chunk_due;
                lo = int'(cfg_m.full_chunk_bytes) + CHUNK_HDR_BYTES;
                if (lo <= MAX_FRAME_BYTES && $urandom_range(0, 3) != 0)
                    it.frame_len = LEN_BITS'($urandom_range(lo, MAX_FRAME_BYTES));
                else
                    it.frame_len = LEN_BITS'($urandom_range(MIN_FRAME_BYTES,
                                                  (lo - 1 > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
                                                                             : lo - 1));
            end
        end
        return it;
    endfunction

    // called at a clock edge; leaves valid high so back-to-back items need no second write
    task automatic send_item(t_in_item it);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        compute_actions(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PING_CODE:    cfg_m.ping_code             = data[CODE_BITS-1:0];
            CFG_CAPTURE_CODE: cfg_m.capture_code          = data[CODE_BITS-1:0];
            CFG_STATUS_CODE:  cfg_m.status_code           = data[CODE_BITS-1:0];
            CFG_CHUNK_CODE:   cfg_m.chunk_code            = data[CODE_BITS-1:0];
            CFG_LINK_TIMEOUT: cfg_m.link_timeout_ms       = data;
            CFG_RETRY_IVL:    cfg_m.retry_interval_ms     = data;
            CFG_KEEPALIVE:    cfg_m.keepalive_interval_ms = data;
            CFG_FULL_CHUNK:   cfg_m.full_chunk_bytes      = data[LEN_BITS-1:0];
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic apply_setup(logic [7:0] ping, logic [7:0] capture, logic [7:0] status,
                               logic [7:0] chunk, logic [15:0] timeout, logic [15:0] retry,
                               logic [15:0] keepalive, logic [15:0] full_bytes);
        wait_idle();
        write_reg(CFG_PING_CODE, {8'h00, ping});
        write_reg(CFG_CAPTURE_CODE, {8'h00, capture});
        write_reg(CFG_STATUS_CODE, {8'h00, status});
        write_reg(CFG_CHUNK_CODE, {8'h00, chunk});
        write_reg(CFG_LINK_TIMEOUT, timeout);
        write_reg(CFG_RETRY_IVL, retry);
        write_reg(CFG_KEEPALIVE, keepalive);
        write_reg(CFG_FULL_CHUNK, full_bytes);
    endtask

    task automatic run_random(int count, int tick_pct);
        repeat (count) send_item(make_random_item(tick_pct));
    endtask

    task automatic test_directed_cases();
        send_item(make_item(MODE_PING_REQ, '0, '0, '0, 1'b0, '0));
        send_item(make_item(MODE_TICK, '0, '0, '0, 1'b0, '0));
        send_item(make_item(MODE_FRAME, 11'd0, '0, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd4, '0, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd5, '0, RST_STATUS_CODE, 1'b0, '0));
        send_item(make_item(MODE_FRAME, 11'd20, 8'hFF, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd8, '0, RST_PING_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd8, '0, RST_PING_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd10, '0, RST_CAPTURE_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd5, '0, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd6, '0, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd2047, '0, RST_STATUS_CODE, 1'b1, '0));
        send_item(make_item(MODE_FRAME, 11'd208, '0, RST_CHUNK_CODE, 1'b1, 16'd0));
        send_item(make_item(MODE_FRAME, 11'd300, '0, RST_CHUNK_CODE, 1'b1, 16'hFFFF));
        // bad CRC on a chunk is still taken; short data ends the download
        send_item(make_item(MODE_FRAME, 11'd100, '0, RST_CHUNK_CODE, 1'b0, 16'd1));
        // chunk with no download running, data shorter than the header
        send_item(make_item(MODE_FRAME, 11'd7, '0, RST_CHUNK_CODE, 1'b1, 16'd2));
        send_item(make_item(MODE_FRAME, 11'd1024, '0, 8'hFF, 1'b1, '0));
        send_item(make_item(MODE_IGNORED, 11'h7FF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF));
        send_item(make_item(MODE_FRAME, 11'd1024, '0, 8'h00, 1'b0, '0));
        send_item(make_item(MODE_FRAME, 11'd40, 8'h01, RST_CHUNK_CODE, 1'b1, 16'd3));
        send_item(make_item(MODE_FRAME, 11'd1025, '0, RST_CHUNK_CODE, 1'b1, 16'd3));
    endtask

    task automatic test_output_backpressure();
        int k;
        hold_reqs++;
        no_idle = 1'b1;
        for (k = 0; k < 12; k++) begin
            if (k % 2 == 0)
                send_item(make_item(MODE_PING_REQ, '0, '0, '0, 1'b0, '0));
            else
                send_item(make_item(MODE_FRAME, 11'd12, '0, cfg_m.capture_code, 1'b1, '0));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_fast_timers();
        apply_setup(8'h00, 8'hFF, 8'h5A, 8'hA5, 16'd1, 16'd1, 16'd1, 16'd1);
        run_random(11, 45);
    endtask

    task automatic test_led_hold();
        send_item(make_item(MODE_FRAME, 11'd30, '0, cfg_m.status_code, 1'b1, '0));
        no_idle = 1'b1;
        repeat (LED_HOLD_MS + 3) send_item(make_item(MODE_TICK, '0, '0, '0, 1'b0, '0));
        no_idle = 1'b0;
    endtask

    task automatic test_moderate_timers();
        apply_setup(8'h21, 8'h12, 8'h11, 8'h13, 16'd9, 16'd3, 16'd4, 16'd64);
        run_random(11, 45);
    endtask

    task automatic test_code_priority();
        // ping, capture and chunk share one code; slow timers never fire
        apply_setup(8'h13, 8'h13, 8'hFE, 8'h13, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1024);
        run_random(10, 40);
    endtask

    task automatic test_final_chunks();
        apply_setup(RST_PING_CODE, RST_CAPTURE_CODE, RST_STATUS_CODE, RST_CHUNK_CODE,
                    16'd20, 16'd6, 16'd11, 16'd1024);
        run_random(11, 45);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_backpressure();
        test_fast_timers();
        test_led_hold();
        test_moderate_timers();
        test_code_priority();
        test_final_chunks();
        wait_idle();

        $display("Sent %0d items over five register setups (%0d writes), checked %0d results",
                 items_sent, reg_writes, results_seen);
        $display("including a long output stall and %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
